>>> rtl/sfcb_pkg.sv
// ----------------------------------------------------------------------------
// sfcb_pkg
// Shared types, constants and the CRC-8 byte update for the frame builder.
// ----------------------------------------------------------------------------
`default_nettype none

package sfcb_pkg;

    // default number of raw data bytes in a raw frame
    localparam int DATA_BYTES_DEF = 8;

    // frame constants
    localparam logic [7:0] START_BYTE = 8'h53;
    localparam logic [7:0] CRC_POLY   = 8'h07;
    localparam logic [7:0] CAL_LENGTH = 8'd2;
    localparam logic [7:0] KEEP_BYTE  = 8'h00;
    localparam int         KEEP_BYTES = 4;

    // calibrated frame: crc sits at byte 5
    localparam int CAL_CRC_IDX = 5;

    // input kinds
    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_IDLE   = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_RAW_MODE  = 2'd0;
    localparam logic [1:0] REG_LINK_EN   = 2'd1;
    localparam logic [1:0] REG_KA_LIMIT  = 2'd2;

    // configuration reset values
    localparam logic       RAW_MODE_RST = 1'b1;
    localparam logic       LINK_EN_RST  = 1'b0;
    localparam logic [7:0] KA_LIMIT_RST = 8'd24;

    // input transaction
    typedef struct packed {
        logic        kind;
        logic [7:0]  node_id;
        logic [7:0]  sample_count;
        logic [63:0] raw_data;
        logic [7:0]  cal_value;
    } t_in;

    // output transaction
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_keepalive;
        logic       frame_end;
    } t_out;

    // job handed from the front to the back
    typedef struct packed {
        logic        has_frame;
        logic        has_keep;
        logic        raw;
        logic [7:0]  node_id;
        logic [7:0]  sample_count;
        logic [63:0] raw_data;
        logic [7:0]  cal_value;
    } t_job;

    // queue status
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // crc-8, poly 0x07, msb first, one byte
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/sensor_frame_crc8_builder.sv
// ----------------------------------------------------------------------------
// sensor_frame_crc8_builder
// Builds CRC-8 framed byte streams from sensor records and idle ticks, with
// an idle keep-alive.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  input     in         i_valid / o_ready    i_data  (sfcb_pkg::t_in)
//  output    out        o_valid / i_ready    o_data  (sfcb_pkg::t_out)
//  config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
//  One output byte per cycle unless stalled; a raw record gives DATA_BYTES+5
//  bytes, a calibrated one 6, a keep-alive 4 more; the serializer sets this.
//  The front accepts a transaction per cycle while the two-entry job queue
//  has room; transactions that produce no bytes only advance the idle count.
//  Reset is synchronous, active low, clears queue and counter, presets config.
//  A stalled output holds its byte while the serializer waits.
//
`default_nettype none

module sensor_frame_crc8_builder #(
    parameter int DATA_BYTES = sfcb_pkg::DATA_BYTES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire sfcb_pkg::t_in  i_data,
    output logic                o_valid,
    input  wire logic           i_ready,
    output sfcb_pkg::t_out      o_data,
    input  wire logic           i_cfg_we,
    input  wire logic [1:0]     i_cfg_index,
    input  wire logic [7:0]     i_cfg_data
);

    sfcb_pkg::t_job    w_job;
    sfcb_pkg::t_job    w_head;
    sfcb_pkg::t_q_stat w_q_stat;
    logic              w_push;
    logic              w_pop;

    // front: accept and classify
    sfcb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_stat    (w_q_stat),
        .o_push      (w_push),
        .o_job       (w_job)
    );

    // job queue
    sfcb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    // back: byte serializer
    sfcb_back #(
        .DATA_BYTES (DATA_BYTES)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_data   (o_data)
    );

    // keep-alive bytes are always zero
    a_keep_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.is_keepalive |-> o_data.out_byte == sfcb_pkg::KEEP_BYTE)
        else $error("keep-alive byte not zero");

    // nothing is shown right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // the queue never takes a job while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_stat.full)
        else $error("job queue overflow");

    // the serializer never pops an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("job queue underflow");

endmodule

`default_nettype wire

>>> rtl/sfcb_front.sv
// ----------------------------------------------------------------------------
// sfcb_front
// Accepts input transactions, keeps the configuration and the idle counter,
// and turns each transaction that yields bytes into a byte serializer job.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcb_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire sfcb_pkg::t_in   i_data,
    input  wire logic            i_cfg_we,
    input  wire logic [1:0]      i_cfg_index,
    input  wire logic [7:0]      i_cfg_data,
    input  wire sfcb_pkg::t_q_stat i_q_stat,
    output logic                 o_push,
    output sfcb_pkg::t_job       o_job
);

    logic       r_raw_mode;
    logic       r_link_en;
    logic [7:0] r_ka_limit;
    logic [7:0] r_idle;
    logic [7:0] n_idle;
    logic       w_accept;
    logic       w_frame;
    logic [7:0] w_base;
    logic [7:0] w_inc;
    logic       w_keep;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_mode <= sfcb_pkg::RAW_MODE_RST;
            r_link_en  <= sfcb_pkg::LINK_EN_RST;
            r_ka_limit <= sfcb_pkg::KA_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sfcb_pkg::REG_RAW_MODE: r_raw_mode <= i_cfg_data[0];
                sfcb_pkg::REG_LINK_EN:  r_link_en  <= i_cfg_data[0];
                sfcb_pkg::REG_KA_LIMIT: r_ka_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_ready  = !i_q_stat.full;
    assign w_accept = i_valid && o_ready;

    // classify and advance the idle counter
    always_comb begin
        w_frame = (i_data.kind == sfcb_pkg::KIND_RECORD) && r_link_en;
        w_base  = w_frame ? 8'd0 : r_idle;
        w_inc   = w_base + 8'd1;
        w_keep  = 1'b0;
        n_idle  = w_inc;
        if (w_inc >= r_ka_limit) begin
            n_idle = 8'd0;
            w_keep = r_link_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle <= 8'd0;
        end else if (w_accept) begin
            r_idle <= n_idle;
        end
    end

    // job for the back end; empty jobs never enter the queue
    always_comb begin
        o_job.has_frame    = w_frame;
        o_job.has_keep     = w_keep;
        o_job.raw          = r_raw_mode;
        o_job.node_id      = i_data.node_id;
        o_job.sample_count = i_data.sample_count;
        o_job.raw_data     = i_data.raw_data;
        o_job.cal_value    = i_data.cal_value;
        o_push             = w_accept && (w_frame || w_keep);
    end

endmodule

`default_nettype wire

>>> rtl/sfcb_queue.sv
// ----------------------------------------------------------------------------
// sfcb_queue
// Two-entry job queue between the front and the serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcb_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire sfcb_pkg::t_job    i_job,
    input  wire logic              i_pop,
    output sfcb_pkg::t_job         o_head,
    output sfcb_pkg::t_q_stat      o_stat
);

    sfcb_pkg::t_job r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_head       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

endmodule

`default_nettype wire

>>> rtl/sfcb_back.sv
// ----------------------------------------------------------------------------
// sfcb_back
// Serializes the queue head into frame and keep-alive bytes, one per cycle
// when not stalled, with a running CRC-8 and a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcb_back #(
    parameter int DATA_BYTES = sfcb_pkg::DATA_BYTES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sfcb_pkg::t_job    i_head,
    input  wire sfcb_pkg::t_q_stat i_q_stat,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output sfcb_pkg::t_out         o_data
);

    // raw frame: crc sits after the header and data bytes
    localparam int RAW_CRC_IDX = DATA_BYTES + 4;
    localparam int IW = $clog2(RAW_CRC_IDX + 1);

    logic          r_act;
    logic          r_frame;
    logic [IW-1:0] r_idx;
    logic [7:0]    r_crc;
    logic          n_act;
    logic          n_frame;
    logic [IW-1:0] n_idx;
    logic [7:0]    n_crc;

    logic          w_adv;
    logic          w_go;
    logic          w_cur_frame;
    logic [IW-1:0] w_idx;
    logic [IW-1:0] w_last;
    logic [7:0]    w_crc;
    logic [7:0]    w_data_byte;
    logic [7:0]    w_byte;
    logic          w_end;

    assign w_adv = !o_valid || i_ready;
    assign w_go  = w_adv && !i_q_stat.empty;

    // current position within the head job
    always_comb begin
        w_cur_frame = r_act ? r_frame : i_head.has_frame;
        w_idx       = r_act ? r_idx : '0;
        w_crc       = r_act ? r_crc : 8'd0;
        w_last      = i_head.raw ? IW'(RAW_CRC_IDX) : IW'(sfcb_pkg::CAL_CRC_IDX);
    end

    // raw data byte selected by position
    always_comb begin
        w_data_byte = 8'd0;
        for (int b = 0; b < DATA_BYTES; b++) begin
            if (w_idx == IW'(b + 4)) begin
                w_data_byte = i_head.raw_data[8*b +: 8];
            end
        end
    end

    // byte generation
    always_comb begin
        if (!w_cur_frame) begin
            w_byte = sfcb_pkg::KEEP_BYTE;
            w_end  = (w_idx == IW'(sfcb_pkg::KEEP_BYTES - 1));
        end else begin
            w_end = (w_idx == w_last);
            if (w_idx == IW'(0)) begin
                w_byte = sfcb_pkg::START_BYTE;
            end else if (w_idx == IW'(1)) begin
                w_byte = i_head.raw ? 8'(DATA_BYTES + 1) : sfcb_pkg::CAL_LENGTH;
            end else if (w_idx == IW'(2)) begin
                w_byte = i_head.node_id;
            end else if (w_idx == IW'(3)) begin
                w_byte = i_head.sample_count;
            end else if (w_end) begin
                w_byte = w_crc;
            end else if (i_head.raw) begin
                w_byte = w_data_byte;
            end else begin
                w_byte = i_head.cal_value;
            end
        end
        // start byte is outside the crc
        n_crc = (w_idx == IW'(0)) ? 8'd0 : sfcb_pkg::crc8_update(w_crc, w_byte);
    end

    // sequencing through frame then keep-alive
    always_comb begin
        o_pop   = 1'b0;
        n_act   = r_act;
        n_frame = r_frame;
        n_idx   = r_idx;
        if (w_go) begin
            if (w_end) begin
                if (w_cur_frame && i_head.has_keep) begin
                    n_act   = 1'b1;
                    n_frame = 1'b0;
                    n_idx   = '0;
                end else begin
                    n_act = 1'b0;
                    o_pop = 1'b1;
                end
            end else begin
                n_act   = 1'b1;
                n_frame = w_cur_frame;
                n_idx   = w_idx + IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act   <= 1'b0;
            r_frame <= 1'b0;
            r_idx   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_act   <= n_act;
            r_frame <= n_frame;
            r_idx   <= n_idx;
            if (w_adv) begin
                o_valid <= w_go;
            end
        end
    end

    // crc and output payload
    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_crc               <= n_crc;
            o_data.out_byte     <= w_byte;
            o_data.is_keepalive <= !w_cur_frame;
            o_data.frame_end    <= w_end;
        end
    end

endmodule

`default_nettype wire

>>> tb/sv/sensor_frame_crc8_builder_tb.sv
// ----------------------------------------------------------------------------
// sensor_frame_crc8_builder_tb
// Self-checking bench for the CRC-8 sensor frame builder. A table of
// directed transactions walks the configuration corners: link off, raw and
// calibrated mode, keep-alive limits 0, 1, 2, 3 and 255. Random phases follow
// under random register settings. Each accepted input goes through a local
// frame predictor. Every output byte is checked in order against the
// predicted stream. Both handshakes idle at random, and in one phase the
// output is held off long enough to back up the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sensor_frame_crc8_builder_tb;

    localparam int DATA_BYTES     = sfcb_pkg::DATA_BYTES_DEF;
    localparam int MAX_GAP        = 5;
    localparam int LONG_HOLD      = 300;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RAND_PHASES    = 8;
    localparam int PHASE_ITEMS    = 19;
    localparam int PRESSURE_PHASE = 5;
    localparam int CALM_PHASE     = 2;

    // typed expectations for directed rows
    localparam int PREDICT   = -1;
    localparam int NO_BYTES  = 0;
    localparam int KEEP_ONLY = sfcb_pkg::KEEP_BYTES;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind      row_kind;
        sfcb_pkg::t_in  item;
        logic [1:0]     reg_idx;
        logic [7:0]     reg_val;
        int             typed_n;
    } t_dir_row;

    // dut ports
    logic           i_clk       = 1'b0;
    logic           i_rst_n     = 1'b0;
    logic           i_valid     = 1'b0;
    logic           o_ready;
    sfcb_pkg::t_in  i_data      = '0;
    logic           o_valid;
    logic           i_ready     = 1'b0;
    sfcb_pkg::t_out o_data;
    logic           i_cfg_we    = 1'b0;
    logic [1:0]     i_cfg_index = sfcb_pkg::REG_RAW_MODE;
    logic [7:0]     i_cfg_data  = 8'h00;

    // predictor state and configuration copy
    logic       model_raw   = sfcb_pkg::RAW_MODE_RST;
    logic       model_link  = sfcb_pkg::LINK_EN_RST;
    logic [7:0] model_limit = sfcb_pkg::KA_LIMIT_RST;
    logic [7:0] idle_ticks  = 8'd0;

    // expected output bytes, oldest first
    sfcb_pkg::t_out frame_bytes_q[$];
    sfcb_pkg::t_out want_byte;
    int             mismatch_count = 0;
    int             quiet_cycles   = 0;

    // handshake pacing controls
    bit send_calm    = 1'b0;
    bit recv_calm    = 1'b0;
    bit hold_request = 1'b0;

    sensor_frame_crc8_builder #(
        .DATA_BYTES(DATA_BYTES)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic sfcb_pkg::t_out frame_byte(input logic [7:0] b, input logic keep,
                                                  input logic last);
        sfcb_pkg::t_out r;
        r.out_byte     = b;
        r.is_keepalive = keep;
        r.frame_end    = last;
        return r;
    endfunction

    function automatic t_dir_row item_row(input logic kind, input logic [7:0] node,
                                          input logic [7:0] cnt, input logic [63:0] data,
                                          input logic [7:0] cal, input int typed_n);
        t_dir_row r;
        r.row_kind          = ROW_ITEM;
        r.item.kind         = kind;
        r.item.node_id      = node;
        r.item.sample_count = cnt;
        r.item.raw_data     = data;
        r.item.cal_value    = cal;
        r.reg_idx           = sfcb_pkg::REG_RAW_MODE;
        r.reg_val           = 8'h00;
        r.typed_n           = typed_n;
        return r;
    endfunction

    function automatic t_dir_row cfg_row(input logic [1:0] idx, input logic [7:0] val);
        t_dir_row r;
        r.row_kind = ROW_CFG;
        r.item     = '0;
        r.reg_idx  = idx;
        r.reg_val  = val;
        r.typed_n  = NO_BYTES;
        return r;
    endfunction

    // frame predictor: bytes caused by one transaction, updates idle count
    function automatic void build_frame(input sfcb_pkg::t_in item,
                                        ref sfcb_pkg::t_out bytes[$]);
        logic [7:0] frame[$];
        logic [7:0] crc;
        logic       fb;
        crc = 8'h00;
        if (item.kind == sfcb_pkg::KIND_RECORD && model_link) begin
            frame = '{sfcb_pkg::START_BYTE, sfcb_pkg::CAL_LENGTH, item.node_id,
                      item.sample_count};
            if (model_raw) begin
                frame[1] = 8'(DATA_BYTES + 1);
                for (int i = 0; i < DATA_BYTES; i++) begin
                    frame.push_back(item.raw_data[8*i +: 8]);
                end
            end else begin
                frame.push_back(item.cal_value);
            end
            // crc covers everything after the start byte, msb first
            foreach (frame[i]) begin
                if (i != 0) begin
                    for (int b = 7; b >= 0; b--) begin
                        fb  = crc[7] ^ frame[i][b];
                        crc = {crc[6:0], 1'b0} ^ (fb ? sfcb_pkg::CRC_POLY : 8'h00);
                    end
                end
                bytes.push_back(frame_byte(frame[i], 1'b0, 1'b0));
            end
            bytes.push_back(frame_byte(crc, 1'b0, 1'b1));
            idle_ticks = 8'd0;
        end
        // every transaction counts toward the keep-alive
        idle_ticks = idle_ticks + 8'd1;
        if (idle_ticks >= model_limit) begin
            idle_ticks = 8'd0;
            if (model_link) begin
                for (int k = 0; k < sfcb_pkg::KEEP_BYTES; k++) begin
                    bytes.push_back(frame_byte(sfcb_pkg::KEEP_BYTE, 1'b1,
                                               k == sfcb_pkg::KEEP_BYTES - 1));
                end
            end
        end
    endfunction

    // offer one transaction, record its expected bytes once accepted
    task automatic send_item(input sfcb_pkg::t_in item, input int typed_n);
        int             gap;
        sfcb_pkg::t_out predicted[$];
        gap = send_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_data  = item;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        build_frame(item, predicted);
        if (typed_n == PREDICT) begin
            foreach (predicted[i]) frame_bytes_q.push_back(predicted[i]);
        end else begin
            for (int k = 0; k < typed_n; k++) begin
                frame_bytes_q.push_back(frame_byte(sfcb_pkg::KEEP_BYTE, 1'b1,
                                                   k == typed_n - 1));
            end
        end
        @(negedge i_clk);
    endtask

    // stop offering, wait for all bytes, then let trailing work settle
    task automatic wait_idle();
        i_valid = 1'b0;
        while (frame_bytes_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        case (idx)
            sfcb_pkg::REG_RAW_MODE: model_raw   = val[0];
            sfcb_pkg::REG_LINK_EN:  model_link  = val[0];
            sfcb_pkg::REG_KA_LIMIT: model_limit = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // output side: random ready gaps, one long hold on request
    initial begin : recv_proc
        int gap;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_request) begin
                i_ready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_request = 1'b0;
            end
            gap = recv_calm ? 0 : $urandom_range(0, MAX_GAP);
            if (gap != 0) begin
                i_ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready = 1'b1;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            @(negedge i_clk);
        end
    end

    // output checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (frame_bytes_q.size() == 0) begin
                $error("unexpected output byte %02h (keep %0b, end %0b)",
                       o_data.out_byte, o_data.is_keepalive, o_data.frame_end);
                mismatch_count = mismatch_count + 1;
            end else begin
                want_byte = frame_bytes_q.pop_front();
                if (o_data.out_byte !== want_byte.out_byte) begin
                    $error("out_byte: expected %02h, got %02h",
                           want_byte.out_byte, o_data.out_byte);
                    mismatch_count = mismatch_count + 1;
                end
                if (o_data.is_keepalive !== want_byte.is_keepalive) begin
                    $error("is_keepalive: expected %0b, got %0b",
                           want_byte.is_keepalive, o_data.is_keepalive);
                    mismatch_count = mismatch_count + 1;
                end
                if (o_data.frame_end !== want_byte.frame_end) begin
                    $error("frame_end: expected %0b, got %0b",
                           want_byte.frame_end, o_data.frame_end);
                    mismatch_count = mismatch_count + 1;
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // stimulus
    initial begin : stim_proc
        t_dir_row       steps[$];
        sfcb_pkg::t_in  item;
        logic [7:0]     lim;

        // directed table, starting from reset settings (raw, link off, limit 24)
        // records and ticks while the link is down produce nothing
        steps.push_back(item_row(sfcb_pkg::KIND_RECORD, 8'h11, 8'h22, 64'h0, 8'h33,
                                 NO_BYTES));
        steps.push_back(item_row(sfcb_pkg::KIND_IDLE, 8'h00, 8'h00, 64'h0, 8'h00, NO_BYTES));
        steps.push_back(cfg_row(sfcb_pkg::REG_LINK_EN, 8'd1));
        steps.push_back(cfg_row(sfcb_pkg::REG_KA_LIMIT, 8'd3));
        // third idle step reaches the limit
        steps.push_back(item_row(sfcb_pkg::KIND_IDLE, 8'hFF, 8'hFF, '1, 8'hFF, KEEP_ONLY));
        // raw frames at the field extremes
        steps.push_back(item_row(sfcb_pkg::KIND_RECORD, 8'h00, 8'h00, 64'h0, 8'h00,
                                 PREDICT));
        steps.push_back(item_row(sfcb_pkg::KIND_RECORD, 8'hFF, 8'hFF, '1, 8'hFF, PREDICT));
        steps.push_back(item_row(sfcb_pkg::KIND_RECORD, 8'hA5, 8'h5A,
                                 64'h0123_4567_89AB_CDEF, 8'h00, PREDICT));
        // a record clears the idle count, so two more ticks give a keep-alive
        steps.push_back(item_row(sfcb_pkg::KIND_IDLE, 8'h00, 8'h00, 64'h0, 8'h00, NO_BYTES));
        steps.push_back(item_row(sfcb_pkg::KIND_IDLE, 8'h00, 8'h00, 64'h0, 8'h00, KEEP_ONLY));
        // calibrated frames
        steps.push_back(cfg_row(sfcb_pkg::REG_RAW_MODE, 8'd0));
        steps.push_back(item_row(sfcb_pkg::KIND_RECORD, 8'h00, 8'h00, 64'h0, 8'h00,
                                 PREDICT));
        steps.push_back(item_row(sfcb_pkg::KIND_RECORD, 8'hFF, 8'hFF,
                                 64'hFEDC_BA98_7654_3210, 8'hFF, PREDICT));
        steps.push_back(item_row(sfcb_pkg::KIND_RECORD, 8'h5A, 8'h3C, 64'h0, 8'h81,
                                 PREDICT));
        // limit 1: every step sends a keep-alive, records get frame plus keep-alive
        steps.push_back(cfg_row(sfcb_pkg::REG_KA_LIMIT, 8'd1));
        steps.push_back(item_row(sfcb_pkg::KIND_RECORD, 8'h42, 8'h07, 64'h0, 8'hC3,
                                 PREDICT));
        steps.push_back(item_row(sfcb_pkg::KIND_IDLE, 8'h00, 8'h00, 64'h0, 8'h00, KEEP_ONLY));
        steps.push_back(cfg_row(sfcb_pkg::REG_RAW_MODE, 8'd1));
        steps.push_back(item_row(sfcb_pkg::KIND_RECORD, 8'h80, 8'h01,
                                 64'h8000_0000_0000_0001, 8'h00, PREDICT));
        // limit zero behaves like always reached
        steps.push_back(cfg_row(sfcb_pkg::REG_KA_LIMIT, 8'd0));
        steps.push_back(item_row(sfcb_pkg::KIND_IDLE, 8'h00, 8'h00, 64'h0, 8'h00, KEEP_ONLY));
        steps.push_back(item_row(sfcb_pkg::KIND_RECORD, 8'h01, 8'h80,
                                 64'h00FF_00FF_00FF_00FF, 8'h00, PREDICT));
        steps.push_back(cfg_row(sfcb_pkg::REG_KA_LIMIT, 8'd255));
        steps.push_back(item_row(sfcb_pkg::KIND_IDLE, 8'h00, 8'h00, 64'h0, 8'h00, NO_BYTES));
        // link down: record dropped, keep-alive clears the count silently
        steps.push_back(cfg_row(sfcb_pkg::REG_LINK_EN, 8'd0));
        steps.push_back(item_row(sfcb_pkg::KIND_RECORD, 8'h33, 8'h44, 64'h1, 8'h55,
                                 NO_BYTES));
        steps.push_back(item_row(sfcb_pkg::KIND_IDLE, 8'h00, 8'h00, 64'h0, 8'h00, NO_BYTES));
        steps.push_back(cfg_row(sfcb_pkg::REG_KA_LIMIT, 8'd2));
        steps.push_back(item_row(sfcb_pkg::KIND_IDLE, 8'h00, 8'h00, 64'h0, 8'h00, NO_BYTES));
        steps.push_back(item_row(sfcb_pkg::KIND_IDLE, 8'h00, 8'h00, 64'h0, 8'h00, NO_BYTES));
        steps.push_back(cfg_row(sfcb_pkg::REG_LINK_EN, 8'd1));
        steps.push_back(item_row(sfcb_pkg::KIND_IDLE, 8'h00, 8'h00, 64'h0, 8'h00, KEEP_ONLY));

        // reset
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part
        foreach (steps[r]) begin
            if (steps[r].row_kind == ROW_CFG) begin
                wait_idle();
                write_reg(steps[r].reg_idx, steps[r].reg_val);
            end else begin
                send_item(steps[r].item, steps[r].typed_n);
            end
        end

        // random phases under random settings
        for (int p = 0; p < RAND_PHASES; p++) begin
            wait_idle();
            case ($urandom_range(0, 7))
                0:       lim = 8'd1;
                1:       lim = 8'd255;
                2:       lim = 8'd0;
                default: lim = 8'($urandom_range(2, 12));
            endcase
            write_reg(sfcb_pkg::REG_RAW_MODE, 8'($urandom_range(0, 1)));
            write_reg(sfcb_pkg::REG_LINK_EN,
                      (p == 3 || p == RAND_PHASES - 1) ? 8'd0 : 8'd1);
            write_reg(sfcb_pkg::REG_KA_LIMIT, lim);
            send_calm = (p == CALM_PHASE || p == PRESSURE_PHASE);
            recv_calm = (p == CALM_PHASE);
            if (p == PRESSURE_PHASE) begin
                hold_request = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                item.kind         = ($urandom_range(0, 3) == 0) ? sfcb_pkg::KIND_IDLE
                                                                : sfcb_pkg::KIND_RECORD;
                item.node_id      = 8'($urandom_range(0, 255));
                item.sample_count = 8'($urandom_range(0, 255));
                item.raw_data     = {$urandom, $urandom};
                item.cal_value    = 8'($urandom_range(0, 255));
                send_item(item, PREDICT);
            end
        end

        // drain and report
        wait_idle();
        if (mismatch_count == 0 && frame_bytes_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/sfcb_pkg.sv
rtl/sfcb_front.sv
rtl/sfcb_queue.sv
rtl/sfcb_back.sv
rtl/sensor_frame_crc8_builder.sv
tb/sv/sensor_frame_crc8_builder_tb.sv
